// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked concurrent assertions with async reset
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define AST_HOLD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// ------------------------------------------------------------------------
// pip_pkg
// shared constants, codes and controller/datapath interface types
// ------------------------------------------------------------------------
package pip_pkg;

	// polygon capacity
	localparam int MAX_VERTICES = 16;
	localparam int VIDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	// field widths
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 5;

	// register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int WIDX_W  = PADDR_W - 2;
	localparam logic [WIDX_W-1:0] REG_VERTEX_COUNT = WIDX_W'(0);

	// cycles from last store read until the parity is final
	localparam int DRAIN_CYCLES = 3;

	// item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST  = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic              start;
		logic              wr_en;
		logic              rd_en;
		logic              rd_first;
		logic [VIDX_W-1:0] rd_addr;
		logic              load_out;
	} pip_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [CNT_W-1:0] vert_num;
	} pip_stat_t;

endpackage

// ===== rtl/pip_ctrl.sv =====
// ------------------------------------------------------------------------
// pip_ctrl
// sequencer for the edge walk: store reads, pipeline drain, result hand-off
// ------------------------------------------------------------------------
module pip_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               opcode,
	output logic               res_valid,
	input  logic               res_ready,
	input  pip_pkg::pip_stat_t stat,
	output pip_pkg::pip_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic [pip_pkg::CNT_W-1:0]   cnt_q;
	logic                        res_valid_q;
	logic                        accept;
	logic                        out_free;
	logic [pip_pkg::CNT_W-1:0]   last_idx;

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign accept     = item_valid && item_ready;
	assign out_free   = !res_valid_q || res_ready;
	assign last_idx   = stat.vert_num - pip_pkg::CNT_W'(1);

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.start    = accept && (opcode == pip_pkg::OP_TEST);
		cmd.wr_en    = accept && (opcode == pip_pkg::OP_WRITE);
		cmd.rd_en    = (state_q == ST_WALK);
		cmd.rd_first = (state_q == ST_WALK) && (cnt_q == '0);
		// first read fetches the closing vertex, then slots in order
		if (cnt_q == '0) begin
			cmd.rd_addr = pip_pkg::VIDX_W'(last_idx);
		end else begin
			cmd.rd_addr = pip_pkg::VIDX_W'(cnt_q - pip_pkg::CNT_W'(1));
		end
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

	// state, counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// result valid: set on hand-off, cleared when the word leaves
			if ((state_q == ST_FINISH) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == pip_pkg::OP_TEST)) begin
						cnt_q <= '0;
						if (stat.vert_num == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (cnt_q == stat.vert_num) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + pip_pkg::CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (cnt_q == pip_pkg::CNT_W'(pip_pkg::DRAIN_CYCLES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + pip_pkg::CNT_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/pip_dpath.sv =====
// ------------------------------------------------------------------------
// pip_dpath
// vertex store, count register, edge crossing pipeline and parity
// ------------------------------------------------------------------------
module pip_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pip_pkg::pip_cmd_t                    cmd,
	output pip_pkg::pip_stat_t                   stat,
	input  logic [pip_pkg::INDEX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]   coord_y,
	output logic                                 inside_res,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pip_pkg::PADDR_W-1:0]          paddr,
	input  logic [pip_pkg::PDATA_W-1:0]          pwdata,
	output logic [pip_pkg::PDATA_W-1:0]          prdata
);

	localparam int CW = pip_pkg::COORD_W;
	localparam int DW = pip_pkg::DIFF_W;
	localparam int PW = pip_pkg::PROD_W;

	logic [pip_pkg::COUNT_W-1:0]        count_q;
	logic                               reg_sel;
	logic signed [CW-1:0]               px_q, py_q;

	// vertex store
	logic signed [CW-1:0]               mem_x_q [pip_pkg::MAX_VERTICES];
	logic signed [CW-1:0]               mem_y_q [pip_pkg::MAX_VERTICES];
	logic [pip_pkg::MAX_VERTICES-1:0]   vld_q;
	logic                               slot_ok;
	logic [pip_pkg::VIDX_W-1:0]         wr_addr;

	// stage 1: read data
	logic signed [CW-1:0]               rd_x_s1, rd_y_s1;
	logic                               hit_s1;
	logic                               rd_s1, edge_s1;
	logic signed [CW-1:0]               xi, yi;
	logic signed [CW-1:0]               prev_x_q, prev_y_q;

	// stage 2: differences
	logic signed [DW-1:0]               dxp_s2, dye_s2, dxe_s2, dpy_s2;
	logic                               cross_s2, edge_s2;

	// stage 3: products
	logic signed [PW-1:0]               lhs_s3, rhs_s3;
	logic                               neg_s3, cross_s3, edge_s3;
	logic                               cmp_ok;

	logic                               parity_q;
	logic                               inside_q;

	// register port
	assign reg_sel = (paddr[pip_pkg::PADDR_W-1:2] == pip_pkg::REG_VERTEX_COUNT);
	assign prdata  = reg_sel ? pip_pkg::PDATA_W'(count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			count_q <= pwdata[pip_pkg::COUNT_W-1:0];
		end
	end

	// clamp count to capacity
	always_comb begin
		if (int'(count_q) > pip_pkg::MAX_VERTICES) begin
			stat.vert_num = pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES);
		end else begin
			stat.vert_num = pip_pkg::CNT_W'(count_q);
		end
	end

	// test point capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
	end

	// store write and registered read
	assign slot_ok = int'(vertex_index) < pip_pkg::MAX_VERTICES;
	assign wr_addr = pip_pkg::VIDX_W'(vertex_index);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && slot_ok) begin
			mem_x_q[wr_addr] <= coord_x;
			mem_y_q[wr_addr] <= coord_y;
		end
		if (cmd.rd_en) begin
			rd_x_s1 <= mem_x_q[cmd.rd_addr];
			rd_y_s1 <= mem_y_q[cmd.rd_addr];
			hit_s1  <= vld_q[cmd.rd_addr];
		end
	end

	// per-slot written flags, unwritten slots read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr_en && slot_ok) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign xi = hit_s1 ? rd_x_s1 : '0;
	assign yi = hit_s1 ? rd_y_s1 : '0;

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			edge_s1 <= 1'b0;
			edge_s2 <= 1'b0;
			edge_s3 <= 1'b0;
		end else begin
			rd_s1   <= cmd.rd_en;
			edge_s1 <= cmd.rd_en && !cmd.rd_first;
			edge_s2 <= edge_s1;
			edge_s3 <= edge_s2;
		end
	end

	// previous vertex of the walk
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			prev_x_q <= xi;
			prev_y_q <= yi;
		end
	end

	// edge differences and straddle test
	always_ff @(posedge clk) begin
		dxp_s2   <= DW'(px_q) - DW'(xi);
		dye_s2   <= DW'(prev_y_q) - DW'(yi);
		dxe_s2   <= DW'(prev_x_q) - DW'(xi);
		dpy_s2   <= DW'(py_q) - DW'(yi);
		cross_s2 <= (yi >= py_q) != (prev_y_q >= py_q);
	end

	// cross-multiplied sides of the intersection inequality
	always_ff @(posedge clk) begin
		lhs_s3   <= dxp_s2 * dye_s2;
		rhs_s3   <= dxe_s2 * dpy_s2;
		neg_s3   <= dye_s2[DW-1];
		cross_s3 <= cross_s2;
	end

	// comparison flips for a falling edge
	assign cmp_ok = neg_s3 ? (lhs_s3 >= rhs_s3) : (lhs_s3 <= rhs_s3);

	// crossing parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (cmd.start) begin
			parity_q <= 1'b0;
		end else if (edge_s3 && cross_s3 && cmp_ok) begin
			parity_q <= !parity_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			inside_q <= parity_q;
		end
	end

	assign inside_res = inside_q;

endmodule

// ===== rtl/point_in_polygon_test_core.sv =====
// ------------------------------------------------------------------------
// point_in_polygon_test_core
// even-odd ray casting test of a point against a stored polygon
// ------------------------------------------------------------------------
// usage
// - item channel (item_valid/item_ready): one word per item; opcode write
//   stores coord_x/coord_y in slot vertex_index and gives no result,
//   opcode test checks the point against the polygon
// - result channel (res_valid/res_ready): one word, inside_res, per test
// - register vertex_count at byte address 0 sets the polygon size, edges
//   wrap from the last vertex to the first; write it while idle
// - a test walks one edge per cycle through the store read port and a
//   shared multiplier pair, then drains the pipeline before the result
//   is loaded; the next item is taken in the cycle after that load
// - the result register lets a new item in while the last result waits;
//   a test finishing while that result waits holds until the word leaves
// - reset clears count, result valid and written flags; slots read as zero
// ------------------------------------------------------------------------
module point_in_polygon_test_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic                                 opcode,
	input  logic [pip_pkg::INDEX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]   coord_y,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic                                 inside_res,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pip_pkg::PADDR_W-1:0]          paddr,
	input  logic [pip_pkg::PDATA_W-1:0]          pwdata,
	output logic [pip_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready
);

	pip_pkg::pip_cmd_t  cmd;
	pip_pkg::pip_stat_t stat;

	assign pready = 1'b1;

	// sequencer
	pip_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.opcode     (opcode),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// store and arithmetic
	pip_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.inside_res   (inside_res),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata)
	);

endmodule

// ===== rtl/pip_checker.sv =====
// ------------------------------------------------------------------------
// pip_checker
// port-level checks on the point in polygon core, bound to the top level
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 item_valid,
	input logic                                 item_ready,
	input logic                                 opcode,
	input logic                                 res_valid,
	input logic                                 res_ready,
	input logic                                 inside_res,
	input logic                                 psel,
	input logic                                 penable,
	input logic                                 pwrite,
	input logic [pip_pkg::PADDR_W-1:0]          paddr,
	input logic [pip_pkg::PDATA_W-1:0]          pwdata,
	input logic [pip_pkg::PDATA_W-1:0]          prdata,
	input logic                                 pready
);

	logic                          res_stall;
	logic                          wr_acc;
	logic                          test_acc;
	logic                          cfg_wr0;
	logic [pip_pkg::COUNT_W-1:0]   wr_cnt;
	logic [pip_pkg::COUNT_W-1:0]   rd_cnt;

	// handshake shorthands
	assign res_stall = res_valid && !res_ready;
	assign wr_acc    = item_valid && item_ready && (opcode == pip_pkg::OP_WRITE);
	assign test_acc  = item_valid && item_ready && (opcode == pip_pkg::OP_TEST);
	assign cfg_wr0   = psel && penable && pwrite && pready && (paddr == '0);
	assign wr_cnt    = pwdata[pip_pkg::COUNT_W-1:0];
	assign rd_cnt    = prdata[pip_pkg::COUNT_W-1:0];

	// stalled result word holds
	`AST_NEXT(a_res_hold, clk, arst_n, res_stall, res_valid && $stable(inside_res), "stalled result changed")

	// register port never waits
	`AST_HOLD(a_pready, clk, arst_n, pready, "pready low")

	// a vertex write never produces a result word
	`AST_NEXT(a_write_silent, clk, arst_n, wr_acc && !res_valid, !res_valid, "result after vertex write")

	// a test result is not valid directly after its accept
	`AST_NEXT(a_test_latency, clk, arst_n, test_acc && !res_valid, !res_valid, "test result too early")

	// count register reads back what was written
	`AST_NEXT(a_count_rdback, clk, arst_n, cfg_wr0, (paddr != '0) || (rd_cnt == $past(wr_cnt)), "count readback")

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (.*);
